### hw/rtl/tksel_pkg.sv
// Shared types and constants for the top-k score selector.
// No dependencies; imported by tksel_cell and top_k_score_selector.
package tksel_pkg;

  localparam int MAX_K_DEF       = 16;
  localparam int MAX_CLASSES_DEF = 1024;

  localparam int SCORE_W = 32;
  localparam int IDX_W   = 10;
  localparam int RANK_W  = 4;
  localparam int TOPK_W  = 5;

  localparam logic [TOPK_W-1:0] TOPK_RESET = TOPK_W'(1);

  typedef struct packed {
    logic                      valid;
    logic signed [SCORE_W-1:0] score;
    logic [IDX_W-1:0]          index;
  } tksel_entry_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic                      upd;   // an item was taken: apply the k limit
    logic                      ins;   // the item is ranked
    logic                      shft;  // report: move entries one place up
    logic signed [SCORE_W-1:0] score;
    logic [IDX_W-1:0]          index;
  } tksel_ctrl_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } tksel_state_t;

endpackage

### hw/rtl/tksel_cell.sv
// One place of the sorted keep list: compare, insert, shift down or up.
// Depends on tksel_pkg.
module tksel_cell
  import tksel_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  tksel_ctrl_t  ctrl,
  input  logic         en,          // this place lies below the effective k
  input  tksel_entry_t prev_ent,
  input  logic         prev_beats,
  input  tksel_entry_t next_ent,
  output tksel_entry_t ent,
  output logic         beats
);

  logic                      valid_r;
  logic                      valid_nxt;
  logic signed [SCORE_W-1:0] score_r;
  logic signed [SCORE_W-1:0] score_nxt;
  logic [IDX_W-1:0]          index_r;
  logic [IDX_W-1:0]          index_nxt;
  logic                      valid_eff;

  assign valid_eff = valid_r & en;
  // newer item wins a tie, so >=
  assign beats     = !valid_eff || (ctrl.score >= score_r);

  assign ent.valid = valid_eff;
  assign ent.score = score_r;
  assign ent.index = index_r;

  always_comb begin
    valid_nxt = valid_r;
    score_nxt = score_r;
    index_nxt = index_r;
    priority if (ctrl.shft) begin
      valid_nxt = next_ent.valid;
      score_nxt = next_ent.score;
      index_nxt = next_ent.index;
    end else if (ctrl.ins && beats && !prev_beats) begin
      valid_nxt = en;
      score_nxt = ctrl.score;
      index_nxt = ctrl.index;
    end else if (ctrl.ins && prev_beats) begin
      valid_nxt = prev_ent.valid & en;
      score_nxt = prev_ent.score;
      index_nxt = prev_ent.index;
    end else if (ctrl.upd) begin
      valid_nxt = valid_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    index_r <= index_nxt;
  end

endmodule

### hw/rtl/top_k_score_selector.sv
// Order: a score is ranked in the cycle it is taken; after the request marked last the
// drain starts and results are registered, one a cycle while the receiver is ready.
// Throughput: one score per cycle within a frame; after the last score the input
// stalls while the chain unloads its kept entries (at most the effective k).
// Reset: synchronous, active low; empties the chain, top_k returns to 1.
// Top level of the top-k selector: compare/insert chain of tksel_cell, report control.
// Depends on tksel_pkg and tksel_cell.
module top_k_score_selector
  import tksel_pkg::*;
#(
  parameter int MAX_K       = MAX_K_DEF,
  parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wen,
  input  logic [TOPK_W-1:0]  cfg_wdata,    // top_k
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,     // score[31:0]
  input  logic               in_tlast,     // last_score
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [47:0]        out_tdata,    // class_index[9:0], best_score[41:10], rank[45:42]
  output logic               out_tuser,    // overflowed
  output logic               out_tlast     // last_result
);

  localparam int ARR_W = $clog2(MAX_CLASSES + 1);
  localparam int CNT_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  tksel_state_t state_r, state_nxt;

  logic [TOPK_W-1:0] top_k_r;
  logic [ARR_W-1:0]  arr_cnt_r;
  logic              ovf_seen_r;
  logic [CNT_W-1:0]  rank_cnt_r;

  logic               out_valid_r;
  logic [IDX_W-1:0]   out_index_r;
  logic [SCORE_W-1:0] out_score_r;
  logic [RANK_W-1:0]  out_rank_r;
  logic               out_ovf_r;
  logic               out_last_r;

  logic        in_acc;
  logic        ovf_now;
  logic        ld;
  logic        drain_done;
  tksel_ctrl_t ctrl;

  tksel_entry_t ent_w  [MAX_K];
  tksel_entry_t next_w [MAX_K];
  tksel_entry_t prev_w [MAX_K];
  logic         beats_w [MAX_K];
  logic         pbeats_w[MAX_K];
  logic         en_w    [MAX_K];

  assign ovf_now = (arr_cnt_r == ARR_W'(MAX_CLASSES));
  assign in_acc  = in_tvalid & in_tready;

  assign ctrl.upd   = in_acc;
  assign ctrl.ins   = in_acc & !ovf_now;
  assign ctrl.shft  = ld;
  assign ctrl.score = in_tdata;
  assign ctrl.index = IDX_W'({{IDX_W{1'b0}}, arr_cnt_r});

  genvar gi;
  generate
    for (gi = 0; gi < MAX_K; gi++) begin : g_cell
      // k of zero acts as one
      assign en_w[gi] = (gi == 0) || (32'(top_k_r) > gi);

      if (gi == 0) begin : g_head
        assign prev_w[gi]   = '{valid: 1'b1, score: '0, index: '0};
        assign pbeats_w[gi] = 1'b0;
      end else begin : g_body
        assign prev_w[gi]   = ent_w[gi-1];
        assign pbeats_w[gi] = beats_w[gi-1];
      end

      if (gi == MAX_K - 1) begin : g_tail
        assign next_w[gi] = '{valid: 1'b0, score: '0, index: '0};
      end else begin : g_mid
        assign next_w[gi] = ent_w[gi+1];
      end

      tksel_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .en         (en_w[gi]),
        .prev_ent   (prev_w[gi]),
        .prev_beats (pbeats_w[gi]),
        .next_ent   (next_w[gi]),
        .ent        (ent_w[gi]),
        .beats      (beats_w[gi])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (in_acc && in_tlast) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_tready  = 1'b0;
    ld         = 1'b0;
    drain_done = 1'b0;
    unique case (state_r)
      ST_COLLECT: begin
        in_tready = 1'b1;
      end
      ST_DRAIN: begin
        ld         = ent_w[0].valid && (!out_valid_r || out_tready);
        drain_done = !ent_w[0].valid || (ld && !next_w[0].valid);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      top_k_r     <= TOPK_RESET;
      arr_cnt_r   <= '0;
      ovf_seen_r  <= 1'b0;
      rank_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wen) begin
        top_k_r <= cfg_wdata;
      end
      if (in_acc) begin
        if (in_tlast) begin
          arr_cnt_r <= '0;
        end else if (!ovf_now) begin
          arr_cnt_r <= arr_cnt_r + ARR_W'(1);
        end
      end
      // flag is held through the report, cleared once the last entry is loaded for output
      if (in_acc && ovf_now) begin
        ovf_seen_r <= 1'b1;
      end else if (state_r == ST_DRAIN && drain_done) begin
        ovf_seen_r <= 1'b0;
      end
      if (in_acc && in_tlast) begin
        rank_cnt_r <= '0;
      end else if (ld) begin
        rank_cnt_r <= rank_cnt_r + CNT_W'(1);
      end
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_index_r <= ent_w[0].index;
      out_score_r <= ent_w[0].score;
      out_rank_r  <= RANK_W'({{RANK_W{1'b0}}, rank_cnt_r});
      out_ovf_r   <= ovf_seen_r;
      out_last_r  <= !next_w[0].valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_rank_r, out_score_r, out_index_r};
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for top_k_score_selector: a predictor tracks the kept pairs
// per frame and checks every reported entry in order. Depends on tksel_pkg and the RTL.
import tksel_pkg::*;

typedef struct packed {
  logic [IDX_W-1:0]          class_index;
  logic signed [SCORE_W-1:0] best_score;
  logic [RANK_W-1:0]         rank;
  logic                      overflowed;
  logic                      last_result;
} ranked_t;

class rank_board;
  logic [TOPK_W-1:0]         top_k;
  logic signed [SCORE_W-1:0] held_score [MAX_K_DEF];
  logic [IDX_W-1:0]          held_index [MAX_K_DEF];
  int                        n_held;
  int                        n_seen;
  bit                        dropped;
  ranked_t                   ranked_q[$];
  int                        errors;

  function new();
    top_k   = TOPK_RESET;
    n_held  = 0;
    n_seen  = 0;
    dropped = 0;
    errors  = 0;
  endfunction

  function void write_top_k(logic [TOPK_W-1:0] v);
    top_k = v;
  endfunction

  // one accepted request; a frame end queues the ranked entries
  function void take_score(logic signed [SCORE_W-1:0] s, bit last);
    int k;
    int pos;
    int j;
    ranked_t r;
    k = (top_k < 1) ? 1 : (top_k > MAX_K_DEF) ? MAX_K_DEF : int'(top_k);
    if (n_held > k) n_held = k;
    if (n_seen >= MAX_CLASSES_DEF) begin
      dropped = 1;
    end else begin
      pos = 0;
      // newest index wins a tie, so stop at the first score not above it
      while (pos < n_held && s < held_score[pos]) pos++;
      if (pos < k) begin
        if (n_held < k) n_held++;
        for (j = n_held - 1; j > pos; j--) begin
          held_score[j] = held_score[j-1];
          held_index[j] = held_index[j-1];
        end
        held_score[pos] = s;
        held_index[pos] = n_seen[IDX_W-1:0];
      end
      n_seen++;
    end
    if (last) begin
      for (j = 0; j < n_held; j++) begin
        r.class_index = held_index[j];
        r.best_score  = held_score[j];
        r.rank        = j[RANK_W-1:0];
        r.overflowed  = dropped;
        r.last_result = (j == n_held - 1);
        ranked_q = {ranked_q, r};
      end
      n_held  = 0;
      n_seen  = 0;
      dropped = 0;
    end
  endfunction

  function void check_ranked(ranked_t got);
    ranked_t want;
    if (ranked_q.size() == 0) begin
      $error("result with nothing expected: index %0d score %0d", got.class_index,
             got.best_score);
      errors++;
      return;
    end
    want = ranked_q.pop_front();
    if (got.class_index !== want.class_index) begin
      $error("class_index: expected %0d, got %0d", want.class_index, got.class_index);
      errors++;
    end
    if (got.best_score !== want.best_score) begin
      $error("best_score: expected %0d, got %0d", want.best_score, got.best_score);
      errors++;
    end
    if (got.rank !== want.rank) begin
      $error("rank: expected %0d, got %0d", want.rank, got.rank);
      errors++;
    end
    if (got.overflowed !== want.overflowed) begin
      $error("overflowed: expected %0d, got %0d", want.overflowed, got.overflowed);
      errors++;
    end
    if (got.last_result !== want.last_result) begin
      $error("last_result: expected %0d, got %0d", want.last_result, got.last_result);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int RAND_ITEMS  = 130;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 4;
  localparam int END_PAD     = 24;
  localparam int IDLE_LIMIT  = 2000;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wen = 1'b0;
  logic [TOPK_W-1:0] cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [47:0]       out_tdata;
  logic              out_tuser;
  logic              out_tlast;

  rank_board board = new();
  bit        calm = 0;
  bit        hold_req = 0;

  top_k_score_selector u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TOPK_W-1:0] pick_k();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return TOPK_W'($urandom_range(17, 31));
    return TOPK_W'($urandom_range(1, 16));
  endfunction

  function automatic logic signed [SCORE_W-1:0] gen_score(int mode);
    unique case (mode)
      1: return $signed($urandom_range(0, 6)) - 3;   // dense ties
      2: begin
        unique case ($urandom_range(0, 4))
          0: return SCORE_MIN;
          1: return SCORE_MAX;
          2: return '0;
          3: return -1;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        board.check_ranked({out_tdata[9:0], out_tdata[41:10], out_tdata[45:42], out_tuser,
                            out_tlast});
      if (in_tvalid && in_tready)
        board.take_score(in_tdata, in_tlast);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wen)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_score(input logic signed [SCORE_W-1:0] s, input bit last);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.ranked_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_top_k(input logic [TOPK_W-1:0] v);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    board.write_top_k(v);
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic send_random_frame(input int len, input int mode, input int cut);
    for (int i = 0; i < len; i++) begin
      if (cut != 0 && i == cut) set_top_k(pick_k());
      send_score(gen_score(mode), i == len - 1);
    end
  endtask

  initial begin
    int len;
    int cut;
    int rand_items;
    int frames;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // widest k, short frame with extremes and ties
    set_top_k(5'd16);
    send_score(SCORE_MIN, 1'b0);
    send_score(SCORE_MAX, 1'b0);
    send_score('0, 1'b0);
    send_score(-1, 1'b0);
    send_score(5, 1'b0);
    send_score(5, 1'b0);
    send_score(SCORE_MAX, 1'b0);
    send_score(SCORE_MIN, 1'b1);
    // zero acts as one: the later of two equal scores wins
    set_top_k(5'd0);
    send_score(3, 1'b0);
    send_score(3, 1'b1);
    // above the maximum acts as the maximum, single-score frame
    set_top_k(5'd17);
    send_score(-7, 1'b1);
    // lower k mid-frame, then raise it again
    set_top_k(5'd4);
    send_score(10, 1'b0);
    send_score(40, 1'b0);
    send_score(30, 1'b0);
    set_top_k(5'd2);
    send_score(20, 1'b0);
    send_score(35, 1'b0);
    set_top_k(5'd31);
    send_score(1, 1'b0);
    send_score(50, 1'b1);

    rand_items = 0;
    frames = 0;
    while (rand_items < RAND_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) set_top_k(pick_k());
      if (frames == 3) begin
        // receiver holds off; the next frame waits at the input while this one drains
        hold_req = 1;
        send_random_frame(16, 0, 0);
        rand_items += 16;
      end
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      cut = (len > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, len - 1) : 0;
      send_random_frame(len, $urandom_range(0, 2), cut);
      rand_items += len;
      frames++;
    end

    calm = 0;
    wait_drained();
    repeat (END_PAD) @(posedge clk);
    if (board.errors == 0 && board.ranked_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

### files.f
hw/rtl/tksel_pkg.sv
hw/rtl/tksel_cell.sv
hw/rtl/top_k_score_selector.sv
bench/tb_top.sv
